### rtl/dsf_pkg.sv
// dsf_pkg: shared widths, codes and divider interface types for the
// descriptor slot free list; no dependencies
`default_nettype none

package dsf_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned INC_W     = 13;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_SIZE = 2'd2;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [INC_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/dsf_div.sv
// dsf_div: iterative restoring divider, 64-bit dividend by 13-bit divisor,
// two quotient bits per cycle; depends on dsf_pkg
`default_nettype none

module dsf_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dsf_pkg::div_req_t req_i,
  output dsf_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned STEPS = 2;
  localparam int unsigned ITER  = dsf_pkg::ADDR_W / STEPS;
  localparam int unsigned ICNT_W = $clog2(ITER);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [ICNT_W-1:0]           cnt_q, cnt_d;
  logic [dsf_pkg::INC_W-1:0]   rem_q, rem_d;
  logic [dsf_pkg::INC_W-1:0]   dvs_q, dvs_d;
  logic [dsf_pkg::ADDR_W-1:0]  quo_q, quo_d;
  logic [dsf_pkg::INC_W-1:0]   step_rem;
  logic [dsf_pkg::ADDR_W-1:0]  step_quo;

  // two dependent restoring steps on a narrow remainder
  always_comb begin
    logic [dsf_pkg::INC_W:0] t;
    step_rem = rem_q;
    step_quo = quo_q;
    for (int k = 0; k < STEPS; k++) begin
      t = {step_rem, step_quo[dsf_pkg::ADDR_W-1]};
      step_quo = {step_quo[dsf_pkg::ADDR_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t = t - {1'b0, dvs_q};
        step_quo[0] = 1'b1;
      end
      step_rem = t[dsf_pkg::INC_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = step_rem;
      quo_d = step_quo;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ICNT_W'(ITER - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

### rtl/descriptor_slot_free_list_top.sv
// descriptor_slot_free_list_top: LIFO free list of descriptor slots with handle
// arithmetic; depends on dsf_pkg and dsf_div
//
// channel  direction  signals
// in       sink       in_valid_i / in_ready_o, operation_i, cpu/gpu_handle_in_i
// out      source     out_valid_o / out_ready_i, cpu/gpu_handle_out_o, slot_index_o,
//                     status_o
// cfg      sink       cfg_we_i, cfg_addr_i, cfg_wdata_i
//
// allocate: stack read, multiply, add, then out
// free: two passes of the shared 2-bit-per-cycle divider
// one transaction at a time; in_ready_o is high only while the sequencer is idle
// a held result stalls the sequencer in its output step until out_ready_i
// no clearing pass after reset: entries below the lowest stack depth reached
// read as their own index
`default_nettype none

module descriptor_slot_free_list_top #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dsf_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [dsf_pkg::ADDR_W-1:0]        cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              operation_i,
  input  wire logic [dsf_pkg::ADDR_W-1:0]        cpu_handle_in_i,
  input  wire logic [dsf_pkg::ADDR_W-1:0]        gpu_handle_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [dsf_pkg::ADDR_W-1:0]             cpu_handle_out_o,
  output logic [dsf_pkg::ADDR_W-1:0]             gpu_handle_out_o,
  output logic [dsf_pkg::OUT_IDX_W-1:0]          slot_index_o,
  output logic [dsf_pkg::STAT_W-1:0]             status_o
);

  localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned PROD_W = IDX_W + dsf_pkg::INC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_DIV_C = 3'd3;
  localparam logic [2:0] S_DIV_G = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [dsf_pkg::ADDR_W-1:0]     cpu_base_q, gpu_base_q;
  logic [dsf_pkg::INC_W-1:0]      inc_q;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [CNT_W-1:0]               min_q, min_d;
  logic [dsf_pkg::ADDR_W-1:0]     cpu_in_q, cpu_in_d;
  logic [dsf_pkg::ADDR_W-1:0]     gpu_in_q, gpu_in_d;
  logic [dsf_pkg::ADDR_W-1:0]     cq_q, cq_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [PROD_W-1:0]              prod_q, prod_d;
  logic [dsf_pkg::ADDR_W-1:0]     res_cpu_q, res_cpu_d;
  logic [dsf_pkg::ADDR_W-1:0]     res_gpu_q, res_gpu_d;
  logic [dsf_pkg::OUT_IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [dsf_pkg::STAT_W-1:0]     res_st_q, res_st_d;
  logic                           out_valid_q, out_valid_d;
  logic [dsf_pkg::ADDR_W-1:0]     out_cpu_q, out_gpu_q;
  logic [dsf_pkg::OUT_IDX_W-1:0]  out_idx_q;
  logic [dsf_pkg::STAT_W-1:0]     out_st_q;
  logic                           out_load;

  logic [IDX_W-1:0]               stack_mem [SLOT_COUNT];
  logic [IDX_W-1:0]               rd_data_q;
  logic [CNT_W-1:0]               top_pos;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_wdata;

  dsf_pkg::div_req_t              div_req;
  dsf_pkg::div_rsp_t              div_rsp;

  dsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign top_pos    = count_q - 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    min_d       = min_q;
    cpu_in_d    = cpu_in_q;
    gpu_in_d    = gpu_in_q;
    cq_d        = cq_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    res_cpu_d   = res_cpu_q;
    res_gpu_d   = res_gpu_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    mem_we      = 1'b0;
    mem_wdata   = cq_q[IDX_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = cpu_in_q - cpu_base_q;
    div_req.divisor  = inc_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cpu_in_d  = cpu_handle_in_i;
          gpu_in_d  = gpu_handle_in_i;
          res_cpu_d = '0;
          res_gpu_d = '0;
          res_idx_d = '0;
          if (operation_i == dsf_pkg::OP_ALLOC) begin
            if (count_q == '0) begin
              res_st_d = dsf_pkg::ST_EMPTY;
              state_d  = S_OUT;
            end else begin
              state_d = S_MUL;
            end
          end else if (inc_q == '0) begin
            res_st_d = dsf_pkg::ST_RANGE;
            state_d  = S_OUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = cpu_handle_in_i - cpu_base_q;
            state_d          = S_DIV_C;
          end
        end
      end
      S_MUL: begin
        // entries below the lowest depth reached still hold their reset value
        if (top_pos < min_q) begin
          idx_d = top_pos[IDX_W-1:0];
        end else begin
          idx_d = rd_data_q;
        end
        prod_d  = PROD_W'(idx_d) * PROD_W'(inc_q);
        state_d = S_ADD;
      end
      S_ADD: begin
        res_cpu_d = cpu_base_q + dsf_pkg::ADDR_W'(prod_q);
        res_gpu_d = gpu_base_q + dsf_pkg::ADDR_W'(prod_q);
        res_idx_d = dsf_pkg::OUT_IDX_W'(dsf_pkg::ADDR_W'(idx_q));
        res_st_d  = dsf_pkg::ST_OK;
        count_d   = top_pos;
        if (top_pos < min_q) begin
          min_d = top_pos;
        end
        state_d = S_OUT;
      end
      S_DIV_C: begin
        if (div_rsp.done) begin
          cq_d             = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = gpu_in_q - gpu_base_q;
          state_d          = S_DIV_G;
        end
      end
      S_DIV_G: begin
        if (div_rsp.done) begin
          if (cq_q != div_rsp.quotient) begin
            res_st_d = dsf_pkg::ST_MISMATCH;
          end else if (cq_q >= dsf_pkg::ADDR_W'(SLOT_COUNT) ||
                       count_q == CNT_W'(SLOT_COUNT)) begin
            res_st_d = dsf_pkg::ST_RANGE;
          end else begin
            mem_we    = 1'b1;
            count_d   = count_q + 1'b1;
            res_idx_d = cq_q[dsf_pkg::OUT_IDX_W-1:0];
            res_st_d  = dsf_pkg::ST_OK;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CNT_W'(SLOT_COUNT);
      min_q       <= CNT_W'(SLOT_COUNT);
      out_valid_q <= 1'b0;
      cpu_base_q  <= '0;
      gpu_base_q  <= '0;
      inc_q       <= dsf_pkg::INC_W'(32);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          dsf_pkg::CFG_CPU_BASE: cpu_base_q <= cfg_wdata_i;
          dsf_pkg::CFG_GPU_BASE: gpu_base_q <= cfg_wdata_i;
          dsf_pkg::CFG_INC_SIZE: inc_q <= cfg_wdata_i[dsf_pkg::INC_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cpu_in_q  <= cpu_in_d;
    gpu_in_q  <= gpu_in_d;
    cq_q      <= cq_d;
    idx_q     <= idx_d;
    prod_q    <= prod_d;
    res_cpu_q <= res_cpu_d;
    res_gpu_q <= res_gpu_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_cpu_q <= res_cpu_q;
      out_gpu_q <= res_gpu_q;
      out_idx_q <= res_idx_q;
      out_st_q  <= res_st_q;
    end
  end

  // free stack storage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[count_q[IDX_W-1:0]] <= mem_wdata;
    end
    rd_data_q <= stack_mem[top_pos[IDX_W-1:0]];
  end

  assign out_valid_o      = out_valid_q;
  assign cpu_handle_out_o = out_cpu_q;
  assign gpu_handle_out_o = out_gpu_q;
  assign slot_index_o     = out_idx_q;
  assign status_o         = out_st_q;

endmodule

`default_nettype wire

### tb/descriptor_slot_free_list_top_tb.sv
`timescale 1ns / 1ps
// descriptor_slot_free_list_top_tb: directed and random checks of the descriptor slot free
// list, predicting each result from a bench copy of the slot stack and the handle arithmetic
// depends on dsf_pkg and descriptor_slot_free_list_top
module descriptor_slot_free_list_top_tb;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned ADDR_W     = dsf_pkg::ADDR_W;
  localparam int unsigned INC_W      = dsf_pkg::INC_W;
  localparam int unsigned OUT_IDX_W  = dsf_pkg::OUT_IDX_W;
  localparam int unsigned STAT_W     = dsf_pkg::STAT_W;
  localparam int unsigned CFG_IDX_W  = dsf_pkg::CFG_IDX_W;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [ADDR_W-1:0]    cpu;
    logic [ADDR_W-1:0]    gpu;
    logic [OUT_IDX_W-1:0] idx;
    logic [STAT_W-1:0]    st;
  } slot_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [ADDR_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 operation_i = dsf_pkg::OP_ALLOC;
  logic [ADDR_W-1:0]    cpu_handle_in_i = '0;
  logic [ADDR_W-1:0]    gpu_handle_in_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ADDR_W-1:0]    cpu_handle_out_o;
  logic [ADDR_W-1:0]    gpu_handle_out_o;
  logic [OUT_IDX_W-1:0] slot_index_o;
  logic [STAT_W-1:0]    status_o;

  // bench copy of the block state and registers
  logic [OUT_IDX_W-1:0] free_stack_m [SLOT_COUNT];
  int unsigned          free_count_m;
  logic [ADDR_W-1:0]    cpu_base_m;
  logic [ADDR_W-1:0]    gpu_base_m;
  logic [INC_W-1:0]     inc_size_m;

  slot_result_t pending_results_q [$];
  int unsigned  held_slots_q [$];
  int           fail_count = 0;
  int           txn_count = 0;
  int           results_checked = 0;
  int           cfg_writes = 0;
  int           status_seen [4] = '{default: 0};
  int           snd_idle_pct = 0;
  int           rcv_idle_pct = 0;
  int           stall_len = 0;

  descriptor_slot_free_list_top #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .cpu_handle_in_i (cpu_handle_in_i),
    .gpu_handle_in_i (gpu_handle_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cpu_handle_out_o(cpu_handle_out_o),
    .gpu_handle_out_o(gpu_handle_out_o),
    .slot_index_o    (slot_index_o),
    .status_o        (status_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic slot_result_t predict_slot(input logic op,
                                                input logic [ADDR_W-1:0] cpu_h,
                                                input logic [ADDR_W-1:0] gpu_h);
    slot_result_t      r;
    logic [ADDR_W-1:0] inc64;
    logic [ADDR_W-1:0] cidx;
    logic [ADDR_W-1:0] gidx;
    logic [ADDR_W-1:0] idx;
    r = '0;
    inc64 = ADDR_W'(inc_size_m);
    if (op == dsf_pkg::OP_ALLOC) begin
      if (free_count_m == 0) begin
        r.st = dsf_pkg::ST_EMPTY;
      end else begin
        free_count_m--;
        idx = ADDR_W'(free_stack_m[free_count_m]);
        r.cpu = cpu_base_m + idx * inc64;
        r.gpu = gpu_base_m + idx * inc64;
        r.idx = idx[OUT_IDX_W-1:0];
        r.st  = dsf_pkg::ST_OK;
      end
    end else if (inc_size_m == '0) begin
      r.st = dsf_pkg::ST_RANGE;
    end else begin
      cidx = (cpu_h - cpu_base_m) / inc64;
      gidx = (gpu_h - gpu_base_m) / inc64;
      if (cidx != gidx) begin
        r.st = dsf_pkg::ST_MISMATCH;
      end else if (cidx >= ADDR_W'(SLOT_COUNT) || free_count_m >= SLOT_COUNT) begin
        r.st = dsf_pkg::ST_RANGE;
      end else begin
        free_stack_m[free_count_m] = cidx[OUT_IDX_W-1:0];
        free_count_m++;
        r.idx = cidx[OUT_IDX_W-1:0];
        r.st  = dsf_pkg::ST_OK;
      end
    end
    return r;
  endfunction

  // address inside slot idx, optionally at a random byte within the stride
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] idx,
                                                  input bit jitter);
    logic [ADDR_W-1:0] off;
    off = '0;
    if (jitter && inc_size_m > 1) off = ADDR_W'($urandom_range(inc_size_m - 1));
    return base + idx * ADDR_W'(inc_size_m) + off;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic send_item(input logic op, input logic [ADDR_W-1:0] cpu_h,
                           input logic [ADDR_W-1:0] gpu_h, output slot_result_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    cpu_handle_in_i <= cpu_h;
    gpu_handle_in_i <= gpu_h;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = predict_slot(op, cpu_h, gpu_h);
    pending_results_q.insert(pending_results_q.size(), r);
    status_seen[r.st]++;
    txn_count++;
  endtask

  task automatic alloc_slot(output slot_result_t r);
    send_item(dsf_pkg::OP_ALLOC, rand64(), rand64(), r);
    if (r.st == dsf_pkg::ST_OK) held_slots_q.insert(held_slots_q.size(), r.idx);
  endtask

  task automatic free_slot(input logic [ADDR_W-1:0] cidx, input logic [ADDR_W-1:0] gidx,
                           input bit jitter, output slot_result_t r);
    send_item(dsf_pkg::OP_FREE, slot_addr(cpu_base_m, cidx, jitter),
              slot_addr(gpu_base_m, gidx, jitter), r);
  endtask

  task automatic free_held_slot();
    slot_result_t      r;
    int unsigned       p;
    logic [ADDR_W-1:0] idx;
    if (held_slots_q.size() == 0) begin
      alloc_slot(r);
    end else begin
      p = $urandom_range(held_slots_q.size() - 1);
      idx = ADDR_W'(held_slots_q[p]);
      held_slots_q.delete(p);
      free_slot(idx, idx, 1'b1, r);
    end
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] addr, input logic [ADDR_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (addr)
      dsf_pkg::CFG_CPU_BASE: cpu_base_m = data;
      dsf_pkg::CFG_GPU_BASE: gpu_base_m = data;
      dsf_pkg::CFG_INC_SIZE: inc_size_m = data[INC_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(input logic [ADDR_W-1:0] cpu_base, input logic [ADDR_W-1:0] gpu_base,
                            input logic [INC_W-1:0] inc);
    logic [ADDR_W-1:0] junk;
    junk = rand64();
    wait_drained();
    cfg_write(dsf_pkg::CFG_CPU_BASE, cpu_base);
    cfg_write(dsf_pkg::CFG_GPU_BASE, gpu_base);
    cfg_write(dsf_pkg::CFG_INC_SIZE, {junk[ADDR_W-1:INC_W], inc});
  endtask

  task automatic test_reset_state();
    slot_result_t r;
    free_slot(ADDR_W'(5), ADDR_W'(5), 1'b0, r);
    alloc_slot(r);
    alloc_slot(r);
  endtask

  task automatic test_handle_checks();
    slot_result_t r;
    free_slot(ADDR_W'(3), ADDR_W'(4), 1'b1, r);
    free_slot(ADDR_W'(5), ADDR_W'(5 + SLOT_COUNT), 1'b0, r);
    free_slot(ADDR_W'(2000), ADDR_W'(2000), 1'b1, r);
    free_slot(ADDR_W'(SLOT_COUNT - 2), ADDR_W'(SLOT_COUNT - 2), 1'b1, r);
  endtask

  task automatic test_double_free();
    slot_result_t r;
    alloc_slot(r);
    alloc_slot(r);
    free_slot(ADDR_W'(SLOT_COUNT - 2), ADDR_W'(SLOT_COUNT - 2), 1'b0, r);
    free_slot(ADDR_W'(SLOT_COUNT - 2), ADDR_W'(SLOT_COUNT - 2), 1'b1, r);
    free_slot(ADDR_W'(SLOT_COUNT - 3), ADDR_W'(SLOT_COUNT - 3), 1'b0, r);
    free_slot(ADDR_W'(SLOT_COUNT - 1), ADDR_W'(SLOT_COUNT - 1), 1'b0, r);
  endtask

  task automatic test_zero_increment();
    slot_result_t r;
    set_config(rand64(), rand64(), '0);
    alloc_slot(r);
    send_item(dsf_pkg::OP_FREE, rand64(), rand64(), r);
    wait_drained();
    cfg_write(CFG_UNUSED, rand64());
    alloc_slot(r);
  endtask

  task automatic test_extreme_config();
    slot_result_t      r;
    logic [ADDR_W-1:0] idx;
    set_config(ALL_ONES, '0, INC_W'(4096));
    alloc_slot(r);
    idx = ADDR_W'(r.idx);
    free_slot(idx, idx, 1'b1, r);
    send_item(dsf_pkg::OP_FREE, '0, '0, r);
    send_item(dsf_pkg::OP_FREE, ALL_ONES, ALL_ONES, r);
    set_config('0, ALL_ONES, INC_W'(1));
    alloc_slot(r);
    send_item(dsf_pkg::OP_FREE, ALL_ONES, ALL_ONES - 1, r);
    send_item(dsf_pkg::OP_FREE, ADDR_W'(7), ADDR_W'(6), r);
  endtask

  task automatic test_pool_exhaustion();
    slot_result_t r;
    int           empties;
    empties = 0;
    set_config(rand64(), rand64(), INC_W'(32));
    while (empties < 3) begin
      alloc_slot(r);
      if (r.st == dsf_pkg::ST_EMPTY) empties++;
    end
    repeat (10) free_held_slot();
  endtask

  task automatic test_output_stall();
    slot_result_t r;
    stall_len = 300;
    alloc_slot(r);
    free_held_slot();
    alloc_slot(r);
    free_held_slot();
  endtask

  task automatic test_random_traffic(input int n, input int alloc_pct,
                                     input logic [ADDR_W-1:0] cpu_base,
                                     input logic [ADDR_W-1:0] gpu_base,
                                     input logic [INC_W-1:0] inc);
    slot_result_t      r;
    int unsigned       pick;
    logic [ADDR_W-1:0] a;
    set_config(cpu_base, gpu_base, inc);
    repeat (n) begin
      pick = $urandom_range(99);
      a = ADDR_W'($urandom_range(SLOT_COUNT - 1));
      if (pick < alloc_pct) begin
        alloc_slot(r);
      end else if (pick < 88) begin
        free_held_slot();
      end else begin
        case ($urandom_range(3))
          0: send_item(dsf_pkg::OP_FREE, rand64(), rand64(), r);
          1: free_slot(a, a + 1 + $urandom_range(50), 1'b1, r);
          2: begin
            a = a + SLOT_COUNT + $urandom_range(100000);
            free_slot(a, a, 1'b1, r);
          end
          default: free_slot(a, a + SLOT_COUNT * (1 + $urandom_range(7)), 1'b1, r);
        endcase
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_len > 0) begin
      stall_len--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results_q.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want = pending_results_q.pop_front();
        if (cpu_handle_out_o !== want.cpu)
          report_mismatch($sformatf("cpu_handle_out got %h want %h", cpu_handle_out_o, want.cpu));
        if (gpu_handle_out_o !== want.gpu)
          report_mismatch($sformatf("gpu_handle_out got %h want %h", gpu_handle_out_o, want.gpu));
        if (slot_index_o !== want.idx)
          report_mismatch($sformatf("slot_index got %0d want %0d", slot_index_o, want.idx));
        if (status_o !== want.st)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.st));
        results_checked++;
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) free_stack_m[i] = OUT_IDX_W'(i);
    free_count_m = SLOT_COUNT;
    cpu_base_m = '0;
    gpu_base_m = '0;
    inc_size_m = INC_W'(32);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 10;
    rcv_idle_pct = 77;
    test_reset_state();
    test_handle_checks();
    test_double_free();
    test_zero_increment();
    test_extreme_config();
    test_pool_exhaustion();
    test_random_traffic(30, 35, ALL_ONES, rand64(), INC_W'(1));

    snd_idle_pct = 77;
    rcv_idle_pct = 10;
    test_output_stall();
    test_random_traffic(50, 50, rand64(), rand64(), INC_W'(4096));

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(40, 55, rand64(), rand64(), INC_W'($urandom_range(4096, 1)));
    test_random_traffic(30, 45, '0, '0, INC_W'(32));

    wait_drained();
    if (pending_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results_q.size()));
    $display("ran %0d transactions, checked %0d results, %0d register writes",
             txn_count, results_checked, cfg_writes);
    $display("status mix: ok %0d, pool empty %0d, mismatch %0d, range or full %0d",
             status_seen[dsf_pkg::ST_OK], status_seen[dsf_pkg::ST_EMPTY],
             status_seen[dsf_pkg::ST_MISMATCH], status_seen[dsf_pkg::ST_RANGE]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_results_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/dsf_pkg.sv
rtl/dsf_div.sv
rtl/descriptor_slot_free_list_top.sv
tb/descriptor_slot_free_list_top_tb.sv
